@@ design/ltre_pkg.sv @@
// Shared types and constants for the left-to-right expression evaluator.
// Used by ltre_muldiv and left_to_right_expression_evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltre_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    PH_EXPECT,
    PH_INNUM,
    PH_AFTER
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SYNTAX,
    ERR_DIVZERO,
    ERR_OVERFLOW
  } err_t;

  typedef enum logic {
    ST_RUN,
    ST_CALC
  } state_t;

  // What follows a combine once its value is known.
  typedef enum logic [1:0] {
    CONT_AFTER,
    CONT_OP,
    CONT_END
  } cont_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

`default_nettype wire

@@ design/ltre_muldiv.sv @@
// Shared iterative multiply / divide unit, one bit per cycle.
// Depends on ltre_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module ltre_muldiv #(
  parameter int W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ltre_pkg::md_req_t req,
  input  wire logic [W-1:0]      a_in,
  input  wire logic [W-1:0]      b_in,
  output ltre_pkg::md_rsp_t      rsp,
  output logic [W-1:0]           result
);
  import ltre_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  p_r, p_nxt;

  logic [W-1:0]  abs_a;
  logic [W-1:0]  abs_b;
  logic [W-1:0]  rem_sh;
  logic [W:0]    diff;

  assign abs_a  = a_in[W-1] ? (~a_in + 1'b1) : a_in;
  assign abs_b  = b_in[W-1] ? (~b_in + 1'b1) : b_in;
  // The remainder stays below the divisor, so its top bit is always clear.
  assign rem_sh = {p_r[W-2:0], x_r[W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    p_nxt    = p_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      neg_nxt  = a_in[W-1] ^ b_in[W-1];
      cnt_nxt  = '0;
      p_nxt    = '0;
      x_nxt    = req.is_div ? abs_a : a_in;
      y_nxt    = req.is_div ? abs_b : b_in;
    end else if (busy_r) begin
      if (div_r) begin
        // Restoring division: the dividend shifts out, quotient bits shift in.
        if (!diff[W]) begin
          p_nxt = diff[W-1:0];
        end else begin
          p_nxt = rem_sh;
        end
        x_nxt = {x_r[W-2:0], ~diff[W]};
      end else begin
        if (y_r[0]) begin
          p_nxt = p_r + x_r;
        end
        x_nxt = {x_r[W-2:0], 1'b0};
        y_nxt = {1'b0, y_r[W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    p_r   <= p_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : p_r;

endmodule

`default_nettype wire

@@ design/left_to_right_expression_evaluator.sv @@
// Left-to-right expression evaluator: one text byte per word, one result word per expression.
// After a byte that completes a multiply or divide, input stalls until the shared
// one-bit-per-cycle multiply/divide unit finishes.
// The result word is registered in the cycle after the end byte is taken, or after the last multiply/divide finishes.
// Reset is synchronous, active low, and returns the evaluator to its empty-expression state.
// Depends on ltre_pkg and ltre_muldiv.
`timescale 1ns / 1ps
`default_nettype none

module left_to_right_expression_evaluator #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  output logic [1:0]       out_error_code
);
  import ltre_pkg::*;

  localparam int W = VALUE_WIDTH;

  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  op_t            pend_r, pend_nxt;
  op_t            nop_r, nop_nxt;
  cont_t          cont_r, cont_nxt;
  err_t           err_r, err_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   opnd_r, opnd_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_value_r, out_value_nxt;
  err_t           out_err_r, out_err_nxt;

  md_req_t        md_req;
  md_rsp_t        md_rsp;
  logic [W-1:0]   md_result;

  logic           accept;
  logic           is_digit;
  logic           is_oper;
  op_t            chr_op;
  logic [W+3:0]   ten_x;
  logic           lit_ovf;
  logic           div_zero;
  logic           long_op;
  logic [W-1:0]   quick_acc;

  logic           do_comb;
  cont_t          comb_cont;
  logic           fin_valid;
  logic [W-1:0]   fin_acc;
  err_t           fin_err;
  cont_t          fin_cont;
  op_t            fin_op;

  assign in_stall = (state_r != ST_RUN) || (out_valid_r && (in_char_in == CHAR_NUL));
  assign accept   = in_valid && !in_stall;

  assign is_digit = (in_char_in >= CHAR_ZERO) && (in_char_in <= CHAR_NINE);
  assign is_oper  = (in_char_in == CHAR_PLUS) || (in_char_in == CHAR_MINUS) ||
                    (in_char_in == CHAR_STAR) || (in_char_in == CHAR_SLASH);

  always_comb begin
    case (in_char_in)
      CHAR_PLUS:  chr_op = OP_ADD;
      CHAR_MINUS: chr_op = OP_SUB;
      CHAR_STAR:  chr_op = OP_MUL;
      default:    chr_op = OP_DIV;
    endcase
  end

  // Ten times the literal plus the new digit, kept wide; any bit at or above
  // the sign position means the literal no longer fits as a positive value.
  assign ten_x   = {1'b0, opnd_r, 3'b000} + {3'b000, opnd_r, 1'b0}
                 + {{W{1'b0}}, in_char_in[3:0]};
  assign lit_ovf = |ten_x[W+3:W-1];

  assign div_zero = (pend_r == OP_DIV) && (opnd_r == '0);
  assign long_op  = (pend_r == OP_MUL) || ((pend_r == OP_DIV) && !div_zero);

  always_comb begin
    case (pend_r)
      OP_ADD:  quick_acc = acc_r + opnd_r;
      OP_SUB:  quick_acc = acc_r - opnd_r;
      default: quick_acc = acc_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    nop_nxt       = nop_r;
    cont_nxt      = cont_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    opnd_nxt      = opnd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    md_req        = '0;
    do_comb       = 1'b0;
    comb_cont     = CONT_AFTER;
    fin_valid     = 1'b0;
    fin_acc       = acc_r;
    fin_err       = err_r;
    fin_cont      = CONT_AFTER;
    fin_op        = chr_op;

    case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (in_char_in == CHAR_NUL) begin
            if ((err_r == ERR_NONE) && (phase_r == PH_INNUM)) begin
              do_comb   = 1'b1;
              comb_cont = CONT_END;
            end else begin
              fin_valid = 1'b1;
              fin_cont  = CONT_END;
              if ((err_r == ERR_NONE) && (phase_r != PH_AFTER)) begin
                fin_err = ERR_SYNTAX;
              end
            end
          end else if (err_r == ERR_NONE) begin
            if (is_digit) begin
              case (phase_r)
                PH_AFTER: begin
                  err_nxt = ERR_SYNTAX;
                end
                PH_INNUM: begin
                  if (lit_ovf) begin
                    err_nxt = ERR_OVERFLOW;
                  end else begin
                    opnd_nxt = ten_x[W-1:0];
                  end
                end
                default: begin
                  opnd_nxt  = {{(W-4){1'b0}}, in_char_in[3:0]};
                  phase_nxt = PH_INNUM;
                end
              endcase
            end else if (in_char_in == CHAR_SPACE) begin
              if (phase_r == PH_INNUM) begin
                do_comb   = 1'b1;
                comb_cont = CONT_AFTER;
              end
            end else if (is_oper) begin
              case (phase_r)
                PH_INNUM: begin
                  do_comb   = 1'b1;
                  comb_cont = CONT_OP;
                end
                PH_AFTER: begin
                  pend_nxt  = chr_op;
                  phase_nxt = PH_EXPECT;
                end
                default: begin
                  err_nxt = ERR_SYNTAX;
                end
              endcase
            end else begin
              err_nxt = ERR_SYNTAX;
            end
          end
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          state_nxt = ST_RUN;
          fin_valid = 1'b1;
          fin_acc   = md_result;
          fin_err   = err_r;
          fin_cont  = cont_r;
          fin_op    = nop_r;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    // Fold the finished literal into the accumulator.
    if (do_comb) begin
      opnd_nxt = '0;
      if (long_op) begin
        md_req.start  = 1'b1;
        md_req.is_div = (pend_r == OP_DIV);
        state_nxt     = ST_CALC;
        cont_nxt      = comb_cont;
        nop_nxt       = chr_op;
      end else begin
        fin_valid = 1'b1;
        fin_acc   = quick_acc;
        fin_err   = div_zero ? ERR_DIVZERO : err_r;
        fin_cont  = comb_cont;
      end
    end

    if (fin_valid) begin
      acc_nxt = fin_acc;
      err_nxt = fin_err;
      case (fin_cont)
        CONT_END: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 32'($signed(fin_acc));
          out_err_nxt   = fin_err;
          acc_nxt       = '0;
          opnd_nxt      = '0;
          pend_nxt      = OP_ADD;
          phase_nxt     = PH_EXPECT;
          err_nxt       = ERR_NONE;
        end
        CONT_OP: begin
          if (fin_err == ERR_NONE) begin
            pend_nxt  = fin_op;
            phase_nxt = PH_EXPECT;
          end
        end
        default: begin
          phase_nxt = PH_AFTER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      phase_r     <= PH_EXPECT;
      pend_r      <= OP_ADD;
      err_r       <= ERR_NONE;
      acc_r       <= '0;
      opnd_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      acc_r       <= acc_nxt;
      opnd_r      <= opnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nop_r       <= nop_nxt;
    cont_r      <= cont_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  ltre_muldiv #(
    .W(W)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a_in   (acc_r),
    .b_in   (opnd_r),
    .rsp    (md_rsp),
    .result (md_result)
  );

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;

`ifndef NO_ASSERTIONS
  // A multiply or divide that ends an expression only starts once the result word is free.
  a_calc_no_pending_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CALC) && (cont_r == CONT_END)) |-> !out_valid_r)
    else $error("result word pending during final multiply/divide");

  // The shared unit only runs while the sequencer waits for it.
  a_unit_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (md_rsp.busy || md_rsp.done) |-> (state_r == ST_CALC))
    else $error("multiply/divide unit active outside its wait state");

  // Once an error is recorded no further arithmetic is started.
  a_err_no_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |-> (state_r == ST_RUN))
    else $error("arithmetic running with an error recorded");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for left_to_right_expression_evaluator: random and directed
// expressions, a scoreboard class that predicts each result word, and random stalls.
// Depends on ltre_pkg and the evaluator RTL.
`timescale 1ns / 1ps

import ltre_pkg::*;

typedef struct {
  logic [31:0] value;
  err_t        code;
} expr_result_t;

class expr_scoreboard;
  localparam logic [31:0] LIT_MAX = 32'h7FFF_FFFF;

  logic [31:0]  acc;
  logic [31:0]  opnd;
  op_t          pend;
  phase_t       ph;
  err_t         err;
  expr_result_t awaited[$];
  int           failures;
  int           exprs;
  int           code_count[4];

  function new();
    failures = 0;
    exprs = 0;
    foreach (code_count[i]) code_count[i] = 0;
    clear_state();
  endfunction

  function void clear_state();
    acc = '0;
    opnd = '0;
    pend = OP_ADD;
    ph = PH_EXPECT;
    err = ERR_NONE;
  endfunction

  // Applies the pending operator to the accumulator and the finished literal.
  function void fold_operand();
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    case (pend)
      OP_ADD: acc = acc + opnd;
      OP_SUB: acc = acc - opnd;
      OP_MUL: acc = acc * opnd;
      default: begin
        if (opnd == 32'd0) begin
          err = ERR_DIVZERO;
        end else begin
          mag_a = acc[31] ? -acc : acc;
          mag_b = opnd[31] ? -opnd : opnd;
          quot = mag_a / mag_b;
          acc = (acc[31] ^ opnd[31]) ? -quot : quot;
        end
      end
    endcase
    opnd = '0;
  endfunction

  function void note_input(logic [7:0] c);
    logic [31:0]  digit;
    expr_result_t r;
    if (c == CHAR_NUL) begin
      if (err == ERR_NONE) begin
        if (ph == PH_INNUM) fold_operand();
        else if (ph == PH_EXPECT) err = ERR_SYNTAX;
      end
      r.value = acc;
      r.code = err;
      awaited.push_back(r);
      clear_state();
    end else if (err == ERR_NONE) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        digit = {24'd0, c - CHAR_ZERO};
        if (ph == PH_AFTER) begin
          err = ERR_SYNTAX;
        end else if (ph == PH_EXPECT) begin
          opnd = digit;
          ph = PH_INNUM;
        end else if (opnd > (LIT_MAX - digit) / 10) begin
          err = ERR_OVERFLOW;
        end else begin
          opnd = opnd * 10 + digit;
        end
      end else if (c == CHAR_SPACE) begin
        if (ph == PH_INNUM) begin
          fold_operand();
          ph = PH_AFTER;
        end
      end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH) begin
        if (ph == PH_EXPECT) begin
          err = ERR_SYNTAX;
        end else begin
          if (ph == PH_INNUM) fold_operand();
          if (err == ERR_NONE) begin
            pend = (c == CHAR_PLUS) ? OP_ADD : (c == CHAR_MINUS) ? OP_SUB
                 : (c == CHAR_STAR) ? OP_MUL : OP_DIV;
            ph = PH_EXPECT;
          end
        end
      end else begin
        err = ERR_SYNTAX;
      end
    end
  endfunction

  function void check_result(logic [31:0] v, logic [1:0] code);
    expr_result_t r;
    if (awaited.size() == 0) begin
      $error("result word with no pending expression: value %0d error_code %0d",
             $signed(v), code);
      failures++;
      return;
    end
    r = awaited.pop_front();
    exprs++;
    code_count[r.code]++;
    if (v !== r.value) begin
      $error("value: expected %0d, actual %0d", $signed(r.value), $signed(v));
      failures++;
    end
    if (code !== r.code) begin
      $error("error_code: expected %0d, actual %0d", r.code, code);
      failures++;
    end
  endfunction
endclass

module tb;
  localparam longint unsigned LIT_LIMIT = 64'd2147483647;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;
  logic [1:0]  out_error_code;

  expr_scoreboard sb;
  logic [7:0]     expr_bytes[$];
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             want_hold;
  int             bytes_sent;

  always #4 clk = ~clk;

  left_to_right_expression_evaluator #(.VALUE_WIDTH(32)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_error_code (out_error_code)
  );

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
  endfunction

  function logic [7:0] pick_op();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CHAR_PLUS;
      1: c = CHAR_MINUS;
      2: c = CHAR_STAR;
      default: c = CHAR_SLASH;
    endcase
    return c;
  endfunction

  // Mostly short literals, with the largest legal one, overflowing ones, zero and leading zeros mixed in.
  function void add_literal();
    int              pick;
    longint unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 45) n = 64'($urandom_range(0, 9));
    else if (pick < 65) n = 64'($urandom_range(10, 9999));
    else if (pick < 77) n = 64'($urandom & 32'h7FFF_FFFF);
    else if (pick < 81) n = LIT_LIMIT;
    else if (pick < 85) n = LIT_LIMIT + 1 + 64'($urandom_range(0, 2000000000));
    else if (pick < 92) n = 0;
    else begin
      add_text("00");
      n = 64'($urandom_range(0, 99));
    end
    add_text($sformatf("%0d", n));
  endfunction

  function void add_gap();
    if ($urandom_range(0, 99) < 35) add_text(" ");
  endfunction

  function void build_random_expr();
    int kind;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) expr_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      add_gap();
      add_literal();
      repeat ($urandom_range(0, 4)) begin
        add_gap();
        expr_bytes.push_back(pick_op());
        add_gap();
        add_literal();
      end
      if (kind < 18) begin
        expr_bytes.push_back(pick_op());
      end else if (kind < 22) begin
        expr_bytes.push_front(pick_op());
      end else if (kind < 30) begin
        pos = $urandom_range(0, expr_bytes.size());
        expr_bytes.insert(pos, 8'($urandom_range(1, 255)));
      end else if (kind < 33) begin
        add_text(" ");
        add_literal();
      end
    end
    expr_bytes.push_back(CHAR_NUL);
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_char_in = b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_expr();
    foreach (expr_bytes[i]) send_byte(expr_bytes[i]);
    expr_bytes.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    expr_bytes.push_back(CHAR_NUL);
    send_expr();
  endtask

  task automatic run_random(input int target);
    while (bytes_sent < target) begin
      build_random_expr();
      send_expr();
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_value, out_error_code);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int guard;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_in = 8'd0;
    send_idle_pct = 31;
    recv_idle_pct = 72;
    want_hold = 1'b0;
    bytes_sent = 0;
    guard = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty expression, divide by zero, trailing operator, leading sign,
    // missing operator, bad character followed by an ignored digit, all operators.
    send_text("");
    send_text("7/0");
    send_text("1+");
    send_text("-5");
    send_text("3 4");
    expr_bytes.push_back(8'hFF);
    send_text("9");
    send_text("9*8-6/4");

    run_random(650);
    send_idle_pct = 72;
    recv_idle_pct = 31;
    run_random(1300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    want_hold = 1'b1;
    run_random(1950);
    in_valid = 1'b0;

    while (sb.awaited.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 50000) begin
      $display("status: fail");
    end else begin
      repeat (80) @(posedge clk);
      $display("Checked %0d expressions from %0d input bytes under varied stalls.",
               sb.exprs, bytes_sent);
      $display("Outcomes: %0d ok, %0d syntax, %0d divide by zero, %0d literal overflow.",
               sb.code_count[ERR_NONE], sb.code_count[ERR_SYNTAX],
               sb.code_count[ERR_DIVZERO], sb.code_count[ERR_OVERFLOW]);
      if (sb.failures == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end
endmodule

@@ files.f @@
design/ltre_pkg.sv
design/ltre_muldiv.sv
design/left_to_right_expression_evaluator.sv
dv/tb.sv
